/* rtl/core/cba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cba_pkg: shared constants and types of the channel byte allocator
// Field widths, fixed scaling constants, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Default number of coded channel slots
  localparam int MAX_CH_DEF  = 16;
  // Ratio denominator and output position of the LFE channel
  localparam int RATIO_SCOPE = 256;
  localparam int LFE_SLOT    = 3;

  // Field widths
  localparam int RATIO_W   = 8;
  localparam int BUDGET_W  = 18;
  localparam int LFEB_W    = 8;
  localparam int BYTES_W   = 16;
  localparam int CHIDX_W   = 4;
  localparam int MINB_W    = 8;
  localparam int CAP_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 13;

  // Divider widths: ratio times a 16-bit signed operand
  localparam int PROD_W = RATIO_W + BYTES_W;
  localparam int QMAG_W = PROD_W - 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES = 1'b1;

  // Reset values of the configuration registers
  localparam logic [MINB_W-1:0] MIN_BYTES_RST = 8'd8;
  localparam logic [CAP_W-1:0]  MAX_BYTES_RST = 13'd1000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TOTAL,
    S_LEFT,
    S_P1_MUL,
    S_P1_STORE,
    S_P2_INIT,
    S_P2_MUL,
    S_P2_STORE,
    S_FIX,
    S_SCAN,
    S_DIST,
    S_DIST_DIV,
    S_DIST_STORE,
    S_CAP_FIX,
    S_OUT
  } cba_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TOTAL,
    OP_LEFT,
    OP_P1_MUL,
    OP_P1_STORE,
    OP_P2_INIT,
    OP_P2_MUL,
    OP_P2_STORE,
    OP_FIX,
    OP_NEXT,
    OP_CAPTURE,
    OP_DIST_MUL,
    OP_DIST_STORE,
    OP_CAP_FIX,
    OP_OUT_INIT,
    OP_OUT_NEXT,
    OP_OUT_LAST
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_phase;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last_i;
    logic alloc_ne_total;
    logic scan_hit;
    logic dist_skip;
    logic out_last;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/cba_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cba_div: signed by positive divider, one quotient bit per cycle
// Truncates toward zero and returns the low 16 bits of the quotient.
// ----------------------------------------------------------------------------
module cba_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [cba_pkg::PROD_W-1:0]   dividend_i,
  input  wire logic        [cba_pkg::BYTES_W-1:0]  divisor_i,
  output      logic                                busy_o,
  output      logic        [cba_pkg::BYTES_W-1:0]  quot_o
);
  import cba_pkg::*;

  localparam int CNT_W = $clog2(QMAG_W);

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                neg_q;
  logic [BYTES_W-1:0]  rem_q;
  logic [QMAG_W-1:0]   dq_q;
  logic [BYTES_W-1:0]  dvs_q;
  logic [PROD_W-1:0]   mag;
  logic [BYTES_W:0]    shifted;
  logic                ge;
  logic [BYTES_W:0]    diff;

  // Magnitude of the dividend and one restoring step
  always_comb begin
    mag     = dividend_i[PROD_W-1] ? (PROD_W'(0) - dividend_i) : dividend_i;
    shifted = {rem_q, dq_q[QMAG_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
  end

  // Track busy and iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QMAG_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Shift quotient bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[PROD_W-1];
      rem_q <= '0;
      dq_q  <= mag[QMAG_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[BYTES_W-1:0] : shifted[BYTES_W-1:0];
      dq_q  <= {dq_q[QMAG_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? (BYTES_W'(0) - dq_q[BYTES_W-1:0]) : dq_q[BYTES_W-1:0];

endmodule
`default_nettype wire

/* rtl/core/cba_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cba_dp: allocator datapath
// Ratio and byte stores, frame state, accumulators, shared divider and the
// output channel mux, all steered by controller commands.
// ----------------------------------------------------------------------------
module cba_dp #(
  parameter int MAX_CH = cba_pkg::MAX_CH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [cba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic        [cba_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic        [cba_pkg::RATIO_W-1:0]   split_ratio_i,
  input  wire logic        [cba_pkg::BUDGET_W-1:0]  total_bits_i,
  input  wire logic                                 lfe_present_i,
  input  wire logic        [cba_pkg::LFEB_W-1:0]    lfe_bytes_i,
  input  wire cba_pkg::cmd_t                        cmd_i,
  output      cba_pkg::sts_t                        sts_o,
  output      logic        [cba_pkg::CHIDX_W-1:0]   channel_index_o,
  output      logic signed [cba_pkg::BYTES_W-1:0]   channel_bytes_o,
  output      logic                                 last_channel_o
);
  import cba_pkg::*;

  localparam int IW       = $clog2(MAX_CH);
  localparam int CW       = $clog2(MAX_CH + 1);
  localparam int SCOPE_SH = $clog2(RATIO_SCOPE);

  logic [MINB_W-1:0]   minb_q;
  logic [CAP_W-1:0]    cap_q;
  logic [RATIO_W-1:0]  ratio_q [MAX_CH];
  logic [BYTES_W-1:0]  bytes_q [MAX_CH];
  logic [MAX_CH-1:0]   capped_q;
  logic [CW-1:0]       count_q;
  logic [BUDGET_W-1:0] budget_q;
  logic                lfe_pres_q;
  logic [LFEB_W-1:0]   lfe_bytes_q;
  logic [BYTES_W-1:0]  total_q, alloc_q, top_q, rsum_q, opnd_q, sq_q;
  logic [IW-1:0]       most_q, i_q, k_q;

  logic                lfe_eff;
  logic [CW-1:0]       cap_lim;
  logic                last_i;
  logic [RATIO_W-1:0]  r_cur;
  logic                fix_op;
  logic [IW-1:0]       rd_addr, out_addr, i_next;
  logic [BYTES_W-1:0]  b_rd, minb_ext, cap_ext;
  logic [CW-1:0]       pos, k_ext, total_ch;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]   prod_adj;
  logic [BYTES_W-1:0]  sq_calc, q16;
  logic                div_start, div_busy;
  logic [BYTES_W-1:0]  total_calc, left_calc;
  logic [BYTES_W-1:0]  p1_b, p2_raw, p2_b, dist_b, fix_b, capfix_b;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [BYTES_W-1:0]  wr_data;

  // Decode current position, addresses and the candidate write values
  always_comb begin
    lfe_eff   = (count_q == '0) ? lfe_present_i : lfe_pres_q;
    cap_lim   = lfe_eff ? CW'(MAX_CH - 1) : CW'(MAX_CH);
    last_i    = CW'(i_q) == (count_q - CW'(1));
    i_next    = last_i ? '0 : i_q + IW'(1);
    r_cur     = ratio_q[i_q];
    minb_ext  = BYTES_W'(minb_q);
    cap_ext   = BYTES_W'(cap_q);
    fix_op    = (cmd_i.op == OP_FIX) || (cmd_i.op == OP_CAP_FIX);
    pos       = (32'(count_q) > LFE_SLOT) ? CW'(LFE_SLOT) : count_q;
    k_ext     = CW'(k_q);
    total_ch  = count_q + CW'(lfe_pres_q);
    out_addr  = (lfe_pres_q && (k_ext > pos)) ? (k_q - IW'(1)) : k_q;
    if (fix_op) begin
      rd_addr = most_q;
    end else if (cmd_i.out_phase) begin
      rd_addr = out_addr;
    end else begin
      rd_addr = i_q;
    end
    b_rd       = bytes_q[rd_addr];
    total_calc = BYTES_W'(budget_q[BUDGET_W-1:3])
               - (lfe_pres_q ? BYTES_W'(lfe_bytes_q) : '0);
    left_calc  = total_q - BYTES_W'(BYTES_W'(count_q) * minb_ext);
    prod       = $signed({1'b0, r_cur}) * $signed(opnd_q);
    // Divide by the ratio scope with a shift, biased so it truncates toward zero
    prod_adj   = prod + (prod[PROD_W-1] ? PROD_W'(RATIO_SCOPE - 1) : PROD_W'(0));
    sq_calc    = prod_adj[SCOPE_SH +: BYTES_W];
    div_start  = cmd_i.op == OP_DIST_MUL;
    p1_b       = sq_q + minb_ext;
    p2_raw     = b_rd - sq_q;
    p2_b       = ($signed(p2_raw) < $signed(minb_ext)) ? minb_ext : p2_raw;
    dist_b     = b_rd + q16;
    fix_b      = b_rd + total_q - alloc_q;
    capfix_b   = b_rd + opnd_q - alloc_q;
  end

  // Select the byte store write
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = i_q;
    wr_data = p1_b;
    case (cmd_i.op)
      OP_P1_STORE:   wr_data = p1_b;
      OP_P2_STORE:   wr_data = p2_b;
      OP_CAPTURE:    wr_data = cap_ext;
      OP_DIST_STORE: wr_data = dist_b;
      OP_FIX: begin
        wr_addr = most_q;
        wr_data = fix_b;
      end
      OP_CAP_FIX: begin
        wr_addr = most_q;
        wr_data = capfix_b;
      end
      default:       wr_en = 1'b0;
    endcase
  end

  cba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (rsum_q),
    .busy_o     (div_busy),
    .quot_o     (q16)
  );

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minb_q <= MIN_BYTES_RST;
      cap_q  <= MAX_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_BYTES: minb_q <= cfg_data_i[MINB_W-1:0];
        REG_MAX_BYTES: cap_q  <= cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame control state: count, budget, LFE info, capped flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      budget_q    <= '0;
      lfe_pres_q  <= 1'b0;
      lfe_bytes_q <= '0;
      capped_q    <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          if (count_q == '0) begin
            budget_q    <= total_bits_i;
            lfe_pres_q  <= lfe_present_i;
            lfe_bytes_q <= lfe_bytes_i;
          end
          if (count_q < cap_lim) begin
            count_q <= count_q + CW'(1);
          end
        end
        OP_CAPTURE:  capped_q[i_q] <= 1'b1;
        OP_OUT_LAST: begin
          count_q  <= '0;
          capped_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Ratio store write on load
  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_LOAD) && (count_q < cap_lim)) begin
      ratio_q[count_q[IW-1:0]] <= split_ratio_i;
    end
  end

  // Byte store write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bytes_q[wr_addr] <= wr_data;
    end
  end

  // Accumulators, indexes and operand register
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TOTAL: begin
        total_q <= total_calc;
        alloc_q <= '0;
        top_q   <= '0;
        rsum_q  <= '0;
        most_q  <= '0;
        i_q     <= '0;
      end
      OP_LEFT:  opnd_q <= left_calc;
      OP_P1_MUL: sq_q <= sq_calc;
      OP_P1_STORE: begin
        alloc_q <= alloc_q + p1_b;
        rsum_q  <= rsum_q + BYTES_W'(r_cur);
        if ($signed(p1_b) > $signed(top_q)) begin
          top_q  <= p1_b;
          most_q <= i_q;
        end
        i_q <= i_next;
      end
      OP_P2_INIT: begin
        opnd_q  <= alloc_q - total_q;
        alloc_q <= '0;
        i_q     <= '0;
      end
      OP_P2_MUL: sq_q <= sq_calc;
      OP_P2_STORE: begin
        alloc_q <= alloc_q + p2_b;
        i_q     <= i_next;
      end
      OP_FIX:   i_q <= '0;
      OP_NEXT:  i_q <= i_next;
      OP_CAPTURE: begin
        opnd_q  <= b_rd - cap_ext;
        rsum_q  <= rsum_q - BYTES_W'(r_cur);
        alloc_q <= '0;
        i_q     <= '0;
      end
      OP_DIST_STORE: begin
        alloc_q <= alloc_q + q16;
        i_q     <= i_next;
      end
      OP_CAP_FIX:  i_q <= '0;
      OP_OUT_INIT: k_q <= '0;
      OP_OUT_NEXT: k_q <= k_q + IW'(1);
      default: ;
    endcase
  end

  // Status to the controller
  always_comb begin
    sts_o.div_busy       = div_busy;
    sts_o.last_i         = last_i;
    sts_o.alloc_ne_total = alloc_q != total_q;
    sts_o.scan_hit       = ($signed(b_rd) > $signed(cap_ext)) && !capped_q[i_q];
    sts_o.dist_skip      = capped_q[i_q] || !($signed(rsum_q) > $signed(BYTES_W'(0)));
    sts_o.out_last       = k_ext == (total_ch - CW'(1));
  end

  // Output channel: LFE slot or a coded channel
  assign channel_index_o = CHIDX_W'(k_q);
  assign channel_bytes_o = (lfe_pres_q && (k_ext == pos)) ? BYTES_W'(lfe_bytes_q) : b_rd;
  assign last_channel_o  = k_ext == (total_ch - CW'(1));

endmodule
`default_nettype wire

/* rtl/core/cba_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cba_ctrl: allocator sequencer
// Loads ratios, then walks share, correction, capping and output phases,
// issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module cba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          last_ratio_i,
  input  wire logic          out_stall_i,
  input  wire cba_pkg::sts_t sts_i,
  output      logic          in_stall_o,
  output      logic          out_valid_o,
  output      cba_pkg::cmd_t cmd_o
);
  import cba_pkg::*;

  cba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:       if (in_valid_i && last_ratio_i) state_d = S_TOTAL;
      S_TOTAL:      state_d = S_LEFT;
      S_LEFT:       state_d = S_P1_MUL;
      S_P1_MUL:     state_d = S_P1_STORE;
      S_P1_STORE:   state_d = sts_i.last_i ? S_P2_INIT : S_P1_MUL;
      S_P2_INIT:    state_d = sts_i.alloc_ne_total ? S_P2_MUL : S_FIX;
      S_P2_MUL:     state_d = S_P2_STORE;
      S_P2_STORE:   state_d = sts_i.last_i ? S_FIX : S_P2_MUL;
      S_FIX:        state_d = S_SCAN;
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = S_DIST;
        end else if (sts_i.last_i) begin
          state_d = S_OUT;
        end
      end
      S_DIST: begin
        if (!sts_i.dist_skip) begin
          state_d = S_DIST_DIV;
        end else if (sts_i.last_i) begin
          state_d = S_CAP_FIX;
        end
      end
      S_DIST_DIV:   if (!sts_i.div_busy) state_d = S_DIST_STORE;
      S_DIST_STORE: state_d = sts_i.last_i ? S_CAP_FIX : S_DIST;
      S_CAP_FIX:    state_d = S_SCAN;
      S_OUT:        if (!out_stall_i && sts_i.out_last) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o.op        = OP_NONE;
    cmd_o.out_phase = state_q == S_OUT;
    in_stall_o      = state_q != S_IDLE;
    out_valid_o     = state_q == S_OUT;
    unique case (state_q)
      S_IDLE:       if (in_valid_i) cmd_o.op = OP_LOAD;
      S_TOTAL:      cmd_o.op = OP_TOTAL;
      S_LEFT:       cmd_o.op = OP_LEFT;
      S_P1_MUL:     cmd_o.op = OP_P1_MUL;
      S_P1_STORE:   cmd_o.op = OP_P1_STORE;
      S_P2_INIT:    if (sts_i.alloc_ne_total) cmd_o.op = OP_P2_INIT;
      S_P2_MUL:     cmd_o.op = OP_P2_MUL;
      S_P2_STORE:   cmd_o.op = OP_P2_STORE;
      S_FIX:        cmd_o.op = OP_FIX;
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          cmd_o.op = OP_CAPTURE;
        end else if (sts_i.last_i) begin
          cmd_o.op = OP_OUT_INIT;
        end else begin
          cmd_o.op = OP_NEXT;
        end
      end
      S_DIST:       cmd_o.op = sts_i.dist_skip ? OP_NEXT : OP_DIST_MUL;
      S_DIST_STORE: cmd_o.op = OP_DIST_STORE;
      S_CAP_FIX:    cmd_o.op = OP_CAP_FIX;
      S_OUT: begin
        if (!out_stall_i) begin
          cmd_o.op = sts_i.out_last ? OP_OUT_LAST : OP_OUT_NEXT;
        end
      end
      default:      cmd_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/channel_byte_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// channel_byte_allocator: per-frame byte budgets for coded audio channels
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  split_ratio, total_bits, lfe_present,
//                                        lfe_bytes, last_ratio
//   out      out  out_valid_o/out_stall_i channel_index, channel_bytes,
//                                        last_channel
//   cfg      in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// A ratio item that does not close the frame is stored and the block idles.
// The closing item runs the allocation: total and left-over setup, a
// multiply and store per channel for the share pass, one check, a multiply
// and store per channel for the overshoot pass when the shares miss the
// budget, one fix, and a cap scan over the channels. Each capped channel
// spreads its excess on a shared serial divider, once per uncapped channel,
// plus a fix; then the output channels leave one per cycle unless stalled.
// Reset clears the frame state and capped flags; no clearing pass is needed.
// A stalled output holds the current channel; input is stalled until the
// frame's last channel is taken.
// ----------------------------------------------------------------------------
module channel_byte_allocator #(
  parameter int MAX_CH = cba_pkg::MAX_CH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic        [cba_pkg::RATIO_W-1:0]   split_ratio_i,
  input  wire logic        [cba_pkg::BUDGET_W-1:0]  total_bits_i,
  input  wire logic                                 lfe_present_i,
  input  wire logic        [cba_pkg::LFEB_W-1:0]    lfe_bytes_i,
  input  wire logic                                 last_ratio_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic        [cba_pkg::CHIDX_W-1:0]   channel_index_o,
  output      logic signed [cba_pkg::BYTES_W-1:0]   channel_bytes_o,
  output      logic                                 last_channel_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [cba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic        [cba_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import cba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  cba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_ratio_i (last_ratio_i),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd)
  );

  // Stores, arithmetic and output mux
  cba_dp #(
    .MAX_CH (MAX_CH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .split_ratio_i   (split_ratio_i),
    .total_bits_i    (total_bits_i),
    .lfe_present_i   (lfe_present_i),
    .lfe_bytes_i     (lfe_bytes_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .channel_index_o (channel_index_o),
    .channel_bytes_o (channel_bytes_o),
    .last_channel_o  (last_channel_o)
  );

endmodule
`default_nettype wire

/* verif/cba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_checker: allocation predictor and result comparison
// Watches the input, output and register channels of the allocator, builds
// the expected channel budgets of every closed frame and compares each
// output item field by field in arrival order.
// ----------------------------------------------------------------------------
module cba_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_stall_i,
  input  wire logic        [cba_pkg::RATIO_W-1:0]  split_ratio_i,
  input  wire logic        [cba_pkg::BUDGET_W-1:0] total_bits_i,
  input  wire logic                                lfe_present_i,
  input  wire logic        [cba_pkg::LFEB_W-1:0]   lfe_bytes_i,
  input  wire logic                                last_ratio_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_stall_i,
  input  wire logic        [cba_pkg::CHIDX_W-1:0]  channel_index_i,
  input  wire logic signed [cba_pkg::BYTES_W-1:0]  channel_bytes_i,
  input  wire logic                                last_channel_i,
  input  wire logic                                cfg_we_i,
  input  wire logic      [cba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic      [cba_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output int                                       fail_count_o,
  output int                                       pending_o
);
  import cba_pkg::*;
  localparam int NCH = MAX_CH_DEF;

  typedef struct packed {
    logic [CHIDX_W-1:0]        idx;
    logic signed [BYTES_W-1:0] bytes;
    logic                      last;
  } chan_budget_t;

  chan_budget_t        budget_q[$];
  logic [MINB_W-1:0]   floor_bytes;
  logic [CAP_W-1:0]    cap_bytes;
  logic [RATIO_W-1:0]  ratios[NCH];
  int                  nratio;
  logic [BUDGET_W-1:0] frame_bits;
  logic                frame_lfe;
  logic [LFEB_W-1:0]   frame_lfe_bytes;

  assign pending_o = budget_q.size();

  // Wrap to 16-bit two's complement
  function automatic int w16(int x);
    logic signed [15:0] t;
    t = x[15:0];
    return int'(t);
  endfunction

  // Work out the budgets of one frame and queue them in output order
  task automatic predict_frame();
    int total, minb, cap, left, alloc, top, rsum, most, excess, t, b, diff, pos, v;
    int bytes[NCH];
    bit capped[NCH];
    bit found;
    total = int'(frame_bits / 8) - (frame_lfe ? int'(frame_lfe_bytes) : 0);
    minb = int'(floor_bytes);
    cap = int'(cap_bytes);
    left = w16(total - nratio * minb);
    alloc = 0; top = 0; rsum = 0; most = 0;
    for (int i = 0; i < nratio; i++) begin
      capped[i] = 0;
      b = w16(int'(ratios[i]) * left / RATIO_SCOPE + minb);
      bytes[i] = b;
      alloc = w16(alloc + b);
      if (b > top) begin
        top = b;
        most = i;
      end
      rsum = w16(rsum + int'(ratios[i]));
    end
    // Overshoot correction, floored
    if (alloc != total) begin
      diff = w16(alloc - total);
      alloc = 0;
      for (int i = 0; i < nratio; i++) begin
        b = w16(bytes[i] - diff * int'(ratios[i]) / RATIO_SCOPE);
        if (b < minb) b = minb;
        bytes[i] = b;
        alloc = w16(alloc + b);
      end
    end
    if (total != alloc) bytes[most] = w16(bytes[most] + total - alloc);
    // Cap one channel at a time and spread its excess
    for (int j = 0; j < nratio; j++) begin
      found = 0;
      excess = 0;
      for (int i = 0; i < nratio; i++) begin
        if (!found && bytes[i] > cap && !capped[i]) begin
          found = 1;
          excess = w16(bytes[i] - cap);
          bytes[i] = cap;
          capped[i] = 1;
          rsum = w16(rsum - int'(ratios[i]));
        end
      end
      if (!found) break;
      alloc = 0;
      for (int i = 0; i < nratio; i++) begin
        if (!capped[i]) begin
          t = (rsum > 0) ? w16(int'(ratios[i]) * excess / rsum) : 0;
          alloc = w16(alloc + t);
          bytes[i] = w16(bytes[i] + t);
        end
      end
      if (alloc != excess) bytes[most] = w16(bytes[most] + excess - alloc);
    end
    // Insert the LFE slot
    pos = (LFE_SLOT < nratio) ? LFE_SLOT : nratio;
    for (int k = 0; k < nratio + int'(frame_lfe); k++) begin
      if (!frame_lfe || k < pos) v = bytes[k];
      else if (k == pos) v = int'(frame_lfe_bytes);
      else v = bytes[k-1];
      budget_q.push_back('{idx: k[3:0], bytes: v[15:0],
                           last: (k + 1 == nratio + int'(frame_lfe))});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    chan_budget_t e;
    logic lfe_now;
    if (!rst_ni) begin
      floor_bytes <= MIN_BYTES_RST;
      cap_bytes <= MAX_BYTES_RST;
      nratio = 0;
      frame_bits = '0;
      frame_lfe = 0;
      frame_lfe_bytes = '0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MIN_BYTES) floor_bytes <= cfg_data_i[MINB_W-1:0];
        else cap_bytes <= cfg_data_i;
      end
      // Compare the output item with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (budget_q.size() == 0) begin
          $error("unexpected item idx=%0d bytes=%0d", channel_index_i, channel_bytes_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = budget_q.pop_front();
          if (e.idx !== channel_index_i || e.bytes !== channel_bytes_i
              || e.last !== last_channel_i) begin
            if (e.idx !== channel_index_i)
              $error("channel_index expected %0d actual %0d", e.idx, channel_index_i);
            if (e.bytes !== channel_bytes_i)
              $error("channel_bytes expected %0d actual %0d", e.bytes, channel_bytes_i);
            if (e.last !== last_channel_i)
              $error("last_channel expected %0d actual %0d", e.last, last_channel_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // Load a ratio; close the frame on last_ratio
      if (in_valid_i && !in_stall_i) begin
        if (nratio == 0) begin
          frame_bits = total_bits_i;
          frame_lfe = lfe_present_i;
          frame_lfe_bytes = lfe_bytes_i;
        end
        lfe_now = frame_lfe;
        if (nratio < (lfe_now ? NCH - 1 : NCH)) begin
          ratios[nratio] = split_ratio_i;
          nratio++;
        end
        if (last_ratio_i) begin
          predict_frame();
          nratio = 0;
        end
      end
    end
  end
endmodule

/* verif/tb_channel_byte_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_byte_allocator: stimulus and verdict for the allocator
// Drives directed and random ratio frames under several register settings
// and idle patterns; the checker predicts and compares every channel item.
// ----------------------------------------------------------------------------
module tb_channel_byte_allocator;
  import cba_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o;
  logic [RATIO_W-1:0] split_ratio_i = '0;
  logic [BUDGET_W-1:0] total_bits_i = '0;
  logic lfe_present_i = 0, last_ratio_i = 0;
  logic [LFEB_W-1:0] lfe_bytes_i = '0;
  logic out_valid_o, out_stall_i = 0;
  logic [CHIDX_W-1:0] channel_index_o;
  logic signed [BYTES_W-1:0] channel_bytes_o;
  logic last_channel_o;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  int fail_count, pending;
  int send_idle = 35, recv_idle = 70;

  channel_byte_allocator uut (.*);

  cba_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .split_ratio_i,
    .total_bits_i, .lfe_present_i, .lfe_bytes_i, .last_ratio_i,
    .out_valid_i(out_valid_o), .out_stall_i, .channel_index_i(channel_index_o),
    .channel_bytes_i(channel_bytes_o), .last_channel_i(last_channel_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Random receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  // Send one item, idling at random first; hold until accepted
  task automatic send_item(input logic [7:0] r, input logic [17:0] tb,
                           input logic lp, input logic [7:0] lb, input logic lr);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    split_ratio_i <= r;
    total_bits_i <= tb;
    lfe_present_i <= lp;
    lfe_bytes_i <= lb;
    last_ratio_i <= lr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Send one frame of n ratios
  task automatic send_frame(input int n, input logic [17:0] tb, input logic lp,
                            input logic [7:0] lb, input int rmode);
    logic [7:0] r;
    for (int i = 0; i < n; i++) begin
      case (rmode)
        0: r = 8'($urandom_range(255));
        1: r = 8'hFF;
        2: r = 8'h00;
        default: r = (i == 0) ? 8'hFF : 8'($urandom_range(3));
      endcase
      send_item(r, $urandom_range(1) ? tb : 18'($urandom), lp, 8'($urandom),
                (i == n - 1));
    end
  endtask

  // Stop sending and wait until the frame is allocated and fully drained
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0 || in_stall_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  initial begin
    int n, sent;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: extremes, LFE placement, overflow of the frame, capping
    send_frame(1, 18'h3FFFF, 0, 8'd0, 1);
    send_frame(2, 18'd0, 1, 8'hFF, 0);
    send_frame(3, 18'd4000, 1, 8'd20, 0);
    send_frame(5, 18'd64000, 1, 8'd10, 3);
    send_frame(18, 18'd50000, 1, 8'd5, 0);
    drain();
    write_reg(REG_MAX_BYTES, 13'd1);
    write_reg(REG_MIN_BYTES, 8'd255);
    send_frame(4, 18'h3FFFF, 0, 8'd0, 1);
    send_frame(4, 18'd100000, 0, 8'd0, 2);
    drain();
    write_reg(REG_MAX_BYTES, 13'h1FFF);
    write_reg(REG_MIN_BYTES, 8'd0);
    send_frame(16, 18'h3FFFF, 0, 8'd0, 0);
    drain();
    // Random phases
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 35 : (ph < 4) ? 70 : 0;
      recv_idle = (ph < 2) ? 70 : (ph < 4) ? 35 : 0;
      drain();
      write_reg(REG_MIN_BYTES, 8'($urandom));
      write_reg(REG_MAX_BYTES, 13'($urandom_range(8191, 1)));
      for (int f = 0; f < 4; f++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 1) : $urandom_range(6, 1);
        send_frame(n, 18'($urandom), 1'($urandom_range(1)), 8'($urandom),
                   $urandom_range(3));
        sent += n;
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
